/* hdl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 decoder with position tracking.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CP_W     = 21;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned LINE_W   = 24;
   localparam int unsigned COL_W    = 16;
   localparam int unsigned OFS_W    = 32;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LONG_LEAD = 2'd2;

   localparam logic [CP_W-1:0]   ERR_CP   = 21'h00FFFE;
   localparam logic [BYTE_W-1:0] NEWLINE  = 8'h0A;

   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
   localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};
   localparam logic [OFS_W-1:0]  OFS_MAX  = {OFS_W{1'b1}};

   typedef struct packed {
      logic [CP_W-1:0]     codepoint;
      logic [STATUS_W-1:0] status;
      logic [LINE_W-1:0]   line_number;
      logic [COL_W-1:0]    column_number;
      logic [OFS_W-1:0]    byte_offset;
   } rsp_type;

endpackage

/* hdl/u8d_ifs.sv */
// ----------------------------------------------------------------------------
// u8d_ifs
// Valid/ready channel interfaces for source bytes and decoded results.
// ----------------------------------------------------------------------------
interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] codepoint;
   logic [1:0]  status;
   logic [23:0] line_number;
   logic [15:0] column_number;
   logic [31:0] byte_offset;

   modport source (output valid, output codepoint, output status, output line_number,
                   output column_number, output byte_offset, input ready);
   modport sink   (input valid, input codepoint, input status, input line_number,
                   input column_number, input byte_offset, output ready);
endinterface

/* hdl/utf8_decoder_with_position_unit.sv */
// ----------------------------------------------------------------------------
// utf8_decoder_with_position_unit
// UTF-8 decoder that tags each codepoint with line, column and byte offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one source byte per transfer; rsp_ch carries one decoded
//   result per completed (or failed) sequence, with its line, column and
//   byte offset of the first byte. Continuation bytes in the middle of a
//   sequence produce no result.
//   Each accepted byte is held in an input register, is stepped through the
//   decoder, and any result lands in the output register: a result is
//   presented from the output register once its final byte has left the
//   input register, and it stays there until it is taken.
//   Throughput is one byte per cycle while the output is not blocked; the
//   decode step is a single pass of shallow logic between the two registers.
//   When the receiver stalls, the held result stays in the output register
//   and the input register may still fill; req_ch.ready drops only when both
//   are occupied and the result has not been taken.
//   Reset is synchronous: it empties both registers, clears the decoder
//   state, and restarts position at line 1, column 0, offset 0.
// ----------------------------------------------------------------------------
module utf8_decoder_with_position_unit (
   input  logic   clock,
   input  logic   reset,
   u8d_req_if.sink   req_ch,
   u8d_rsp_if.source rsp_ch
);
   import u8d_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff;
   rsp_type          out_data_ff;
   logic             advance;
   logic             fire;
   logic             emit;
   rsp_type          step_result;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   u8d_step u_step (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_byte_ff),
      .emit      (emit),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.codepoint     = out_data_ff.codepoint;
   assign rsp_ch.status        = out_data_ff.status;
   assign rsp_ch.line_number   = out_data_ff.line_number;
   assign rsp_ch.column_number = out_data_ff.column_number;
   assign rsp_ch.byte_offset   = out_data_ff.byte_offset;

`ifndef SYNTHESIS
   // A byte waiting in the input register is kept while the output is blocked.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost during stall");

   // A long lead byte always reports codepoint zero.
   a_long_lead_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.status == STATUS_LONG_LEAD |->
      out_data_ff.codepoint == '0)
      else $error("long lead with nonzero codepoint");

   // Malformed results carry the replacement value.
   a_malformed_cp: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.status == STATUS_MALFORMED |->
      out_data_ff.codepoint == ERR_CP)
      else $error("malformed result with wrong codepoint");

   // Every delivered result has a line and a column of at least one.
   a_position_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff.line_number != '0 && out_data_ff.column_number != '0)
      else $error("result with zero line or column");
`endif

endmodule

/* hdl/u8d_step.sv */
// ----------------------------------------------------------------------------
// u8d_step
// Decoder state and single-byte step logic: sequence assembly and position.
// ----------------------------------------------------------------------------
module u8d_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             data_byte,
   output logic                   emit,
   output u8d_pkg::rsp_type       result
);
   import u8d_pkg::*;

   logic [1:0]        pending_ff,  pending_in;
   logic [CP_W-1:0]   partial_ff,  partial_in;
   logic [OFS_W-1:0]  start_ff,    start_in;
   logic [OFS_W-1:0]  seen_ff,     seen_in;
   logic [LINE_W-1:0] line_ff,     line_in;
   logic [COL_W-1:0]  col_ff,      col_in;
   logic              nl_ff,       nl_in;

   logic [CP_W-1:0]     cp;
   logic [STATUS_W-1:0] st;
   logic [OFS_W-1:0]    ofs;
   logic [CP_W-1:0]     shifted;

   assign shifted = {partial_ff[CP_W-7:0], data_byte[5:0]};

   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      start_in   = start_ff;
      seen_in    = (seen_ff != OFS_MAX) ? seen_ff + OFS_W'(1) : seen_ff;
      emit       = 1'b0;
      cp         = '0;
      st         = STATUS_OK;
      ofs        = start_ff;

      if (pending_ff != 2'd0) begin
         if (data_byte[7:6] != 2'b10) begin
            // A broken sequence is reported with the offset of its first byte.
            pending_in = 2'd0;
            partial_in = '0;
            emit       = 1'b1;
            cp         = ERR_CP;
            st         = STATUS_MALFORMED;
         end else begin
            partial_in = shifted;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               emit = 1'b1;
               cp   = shifted;
            end
         end
      end else begin
         start_in = seen_ff;
         ofs      = seen_ff;
         priority if (data_byte[7] == 1'b0) begin
            emit = 1'b1;
            cp   = CP_W'(data_byte);
         end else if (data_byte[7:6] == 2'b10) begin
            emit = 1'b1;
            cp   = ERR_CP;
            st   = STATUS_MALFORMED;
         end else if (data_byte[7:5] == 3'b110) begin
            partial_in = CP_W'(data_byte[4:0]);
            pending_in = 2'd1;
         end else if (data_byte[7:4] == 4'b1110) begin
            partial_in = CP_W'(data_byte[3:0]);
            pending_in = 2'd2;
         end else if (data_byte[7:3] == 5'b11110) begin
            partial_in = CP_W'(data_byte[2:0]);
            pending_in = 2'd3;
         end else begin
            emit = 1'b1;
            cp   = '0;
            st   = STATUS_LONG_LEAD;
         end
      end

      // Position moves only when a result goes out.
      line_in = line_ff;
      col_in  = col_ff;
      nl_in   = nl_ff;
      if (emit) begin
         if (nl_ff) begin
            if (line_ff != LINE_MAX) begin
               line_in = line_ff + LINE_W'(1);
            end
            col_in = COL_W'(1);
         end else if (col_ff != COL_MAX) begin
            col_in = col_ff + COL_W'(1);
         end
         nl_in = (st == STATUS_OK) && (cp == CP_W'(NEWLINE));
      end

      result.codepoint     = cp;
      result.status        = st;
      result.line_number   = line_in;
      result.column_number = col_in;
      result.byte_offset   = ofs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         partial_ff <= '0;
         start_ff   <= '0;
         seen_ff    <= '0;
         line_ff    <= LINE_W'(1);
         col_ff     <= '0;
         nl_ff      <= 1'b0;
      end else if (fire) begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
         start_ff   <= start_in;
         seen_ff    <= seen_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         nl_ff      <= nl_in;
      end
   end

`ifndef SYNTHESIS
   // The offset of a completed sequence never lies ahead of the bytes consumed.
   a_start_behind_seen: assert property (@(posedge clock) disable iff (reset)
      start_ff <= seen_ff)
      else $error("sequence start ahead of byte count");

   // Each step inside a sequence loads the remaining count it computed.
   a_pending_drop: assert property (@(posedge clock) disable iff (reset)
      fire && pending_ff != 2'd0 |=> pending_ff == $past(pending_in))
      else $error("pending count did not follow the step");

   // Column counting restarts right after a newline was emitted.
   a_column_restart: assert property (@(posedge clock) disable iff (reset)
      fire && emit && nl_ff |-> result.column_number == COL_W'(1))
      else $error("column did not restart after newline");
`endif

endmodule

/* verif/tb_utf8_decoder_with_position_unit.sv */
// ----------------------------------------------------------------------------
// tb_utf8_decoder_with_position_unit
// Feeds byte streams of well-formed, broken and stray UTF-8 into the decoder.
// Each accepted byte is run through a behavioral decoder that tracks line,
// column and offset, and every result the block emits is checked against it.
// ----------------------------------------------------------------------------
module tb_utf8_decoder_with_position_unit;
   import u8d_pkg::*;

   localparam int unsigned STUCK_LIMIT = 2000;
   localparam int unsigned LONG_HOLD   = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8d_req_if req_ch ();
   u8d_rsp_if rsp_ch ();

   utf8_decoder_with_position_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #10 clock = ~clock;

   // Bytes still to be offered, and the results they are known to cause.
   logic [BYTE_W-1:0] source_text [$];
   rsp_type           predicted_chars [$];

   // Decoder state as seen by the checker.
   logic [1:0]        pend_cnt      = '0;
   logic [CP_W-1:0]   accum         = '0;
   logic [OFS_W-1:0]  seq_start     = '0;
   logic [OFS_W-1:0]  ofs_count     = '0;
   logic [LINE_W-1:0] cur_line      = LINE_W'(1);
   logic [COL_W-1:0]  cur_col       = '0;
   logic              after_newline = 1'b0;

   int unsigned error_count  = 0;
   int unsigned stuck_cycles = 0;

   // Traffic shaping controls, set per phase.
   bit          bursty       = 1'b0;
   bit          stall_on     = 1'b0;
   bit          hold_request = 1'b0;
   bit          byte_taken   = 1'b0;
   int unsigned burst_left   = 0;
   int unsigned gap_left     = 0;
   int unsigned hold_left    = 0;
   logic [31:0] stall_mask   = '0;
   logic [4:0]  stall_phase  = '0;

   logic [BYTE_W-1:0] opening [23];

   function automatic void record_char(logic [CP_W-1:0] cp, logic [STATUS_W-1:0] st,
                                       logic [OFS_W-1:0] ofs);
      rsp_type item;
      if (after_newline) begin
         if (cur_line != LINE_MAX) cur_line++;
         cur_col = COL_W'(1);
      end else if (cur_col != COL_MAX) begin
         cur_col++;
      end
      // Only a cleanly decoded line feed starts a new line; error results never do.
      after_newline = (st == STATUS_OK) && (cp == NEWLINE);
      item.codepoint     = cp;
      item.status        = st;
      item.line_number   = cur_line;
      item.column_number = cur_col;
      item.byte_offset   = ofs;
      predicted_chars.push_back(item);
   endfunction

   function automatic void decode_byte(logic [BYTE_W-1:0] b);
      logic [OFS_W-1:0] here;
      here = ofs_count;
      if (ofs_count != OFS_MAX) ofs_count++;
      if (pend_cnt != 2'd0) begin
         if (b[7:6] != 2'b10) begin
            // The offending byte is swallowed along with the partial sequence.
            pend_cnt = 2'd0;
            accum    = '0;
            record_char(ERR_CP, STATUS_MALFORMED, seq_start);
         end else begin
            accum = {accum[CP_W-7:0], b[5:0]};
            pend_cnt--;
            if (pend_cnt == 2'd0) record_char(accum, STATUS_OK, seq_start);
         end
      end else begin
         seq_start = here;
         casez (b)
            8'b0???????: record_char({13'd0, b}, STATUS_OK, here);
            8'b10??????: record_char(ERR_CP, STATUS_MALFORMED, here);
            8'b110?????: begin
               accum    = {16'd0, b[4:0]};
               pend_cnt = 2'd1;
            end
            8'b1110????: begin
               accum    = {17'd0, b[3:0]};
               pend_cnt = 2'd2;
            end
            8'b11110???: begin
               accum    = {18'd0, b[2:0]};
               pend_cnt = 2'd3;
            end
            default: record_char('0, STATUS_LONG_LEAD, here);
         endcase
      end
   endfunction

   // Encodes the low bits of a 21-bit value that fit the given length, overlong forms included.
   function automatic void put_char(logic [CP_W-1:0] cp, int unsigned len);
      case (len)
         1: source_text.push_back({1'b0, cp[6:0]});
         2: begin
            source_text.push_back({3'b110, cp[10:6]});
            source_text.push_back({2'b10, cp[5:0]});
         end
         3: begin
            source_text.push_back({4'b1110, cp[15:12]});
            source_text.push_back({2'b10, cp[11:6]});
            source_text.push_back({2'b10, cp[5:0]});
         end
         default: begin
            source_text.push_back({5'b11110, cp[20:18]});
            source_text.push_back({2'b10, cp[17:12]});
            source_text.push_back({2'b10, cp[11:6]});
            source_text.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // A lead byte, fewer continuation bytes than it asks for, then a byte that
   // cannot continue the sequence.
   function automatic void put_broken();
      int unsigned      len;
      int unsigned      good;
      logic [CP_W-1:0]  cp;
      logic [BYTE_W-1:0] bad;
      len  = $urandom_range(2, 4);
      good = $urandom_range(0, len - 2);
      cp   = CP_W'($urandom());
      case (len)
         2:       source_text.push_back({3'b110, cp[4:0]});
         3:       source_text.push_back({4'b1110, cp[3:0]});
         default: source_text.push_back({5'b11110, cp[2:0]});
      endcase
      repeat (good) source_text.push_back({2'b10, 6'($urandom())});
      bad = BYTE_W'($urandom_range(0, 255));
      if (bad[7:6] == 2'b10) bad[6] = 1'b1;
      source_text.push_back(bad);
   endfunction

   function automatic void put_random_text(int unsigned count);
      int unsigned start_size;
      int unsigned pick;
      start_size = source_text.size();
      while (source_text.size() - start_size < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            if ($urandom_range(0, 99) < 15) source_text.push_back(NEWLINE);
            else source_text.push_back(BYTE_W'($urandom_range(0, 127)));
         end else if (pick < 60) put_char(CP_W'($urandom()), 2);
         else if (pick < 75) put_char(CP_W'($urandom()), 3);
         else if (pick < 85) put_char(CP_W'($urandom()), 4);
         else if (pick < 90) source_text.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
         else if (pick < 94) source_text.push_back(BYTE_W'($urandom_range(8'hF8, 8'hFF)));
         else put_broken();
      end
   endfunction

   task automatic wait_for_drain();
      while (source_text.size() != 0 || predicted_chars.size() != 0) @(posedge clock);
   endtask

   // Source side: one transfer per rising edge at most, new bytes driven at
   // the falling edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         decode_byte(req_ch.data_byte);
         void'(source_text.pop_front());
         byte_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= '0;
      end else if (!(req_ch.valid && !byte_taken)) begin
         if (bursty && gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (source_text.size() != 0) begin
            req_ch.valid     <= 1'b1;
            req_ch.data_byte <= source_text[0];
            if (bursty) begin
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 8);
               end else begin
                  burst_left--;
               end
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      byte_taken = 1'b0;
   end

   // Result side: a long hold when asked for, otherwise a random stall mask when stalls are on, else always ready.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!stall_on) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         if (stall_phase == 0) begin
            stall_mask = ($urandom_range(0, 3) == 0) ? $urandom() : ($urandom() & $urandom());
         end
         rsp_ch.ready <= !stall_mask[stall_phase];
         stall_phase++;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_chars.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: cp %h st %0d line %0d col %0d ofs %0d",
                        rsp_ch.codepoint, rsp_ch.status, rsp_ch.line_number,
                        rsp_ch.column_number, rsp_ch.byte_offset);
         end else begin
            want = predicted_chars.pop_front();
            if (rsp_ch.codepoint !== want.codepoint || rsp_ch.status !== want.status ||
                rsp_ch.line_number !== want.line_number ||
                rsp_ch.column_number !== want.column_number ||
                rsp_ch.byte_offset !== want.byte_offset) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: expected cp %h st %0d line %0d col %0d ofs %0d",
                           want.codepoint, want.status, want.line_number,
                           want.column_number, want.byte_offset);
                  $display("          actual   cp %h st %0d line %0d col %0d ofs %0d",
                           rsp_ch.codepoint, rsp_ch.status, rsp_ch.line_number,
                           rsp_ch.column_number, rsp_ch.byte_offset);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      opening = '{
         8'h00, 8'h7F, 8'h0A, 8'h0A, 8'h41, 8'h80, 8'hBF, 8'hF8, 8'hFF,
         8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
         8'hC2, 8'h41, 8'hF0, 8'h90, 8'h0A};

      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Field extremes, every sequence length, the error kinds, back to back.
      foreach (opening[i]) source_text.push_back(opening[i]);
      wait_for_drain();

      bursty   = 1'b1;
      stall_on = 1'b1;
      put_random_text(200);
      wait_for_drain();

      // Keep offering bytes while the result side is held off, so both
      // internal registers fill and the input stalls.
      bursty   = 1'b0;
      stall_on = 1'b0;
      put_random_text(60);
      hold_request = 1'b1;
      wait_for_drain();

      repeat (7) begin
         bursty   = $urandom_range(0, 3) != 0;
         stall_on = $urandom_range(0, 3) != 0;
         put_random_text(40);
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0 && predicted_chars.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/u8d_pkg.sv
hdl/u8d_ifs.sv
hdl/u8d_step.sv
hdl/utf8_decoder_with_position_unit.sv
verif/tb_utf8_decoder_with_position_unit.sv
